// ===== hdl/brs_pkg.sv =====
package brs_pkg;

    // Default widths of the address and length fields.
    localparam int ADDRESS_BITS_DEF = 48;
    localparam int LENGTH_BITS_DEF  = 32;

    // Divisor and configuration widths.
    localparam int DIV_W  = 32;
    localparam int PAGE_W = 17;
    localparam int CFG_W  = 32;

    // Register reset values.
    localparam logic [DIV_W-1:0]  CHUNK_RESET = 32'd2048;
    localparam logic [PAGE_W-1:0] PAGE_RESET  = 17'd8;

    // Register indexes.
    typedef enum logic [0:0] {
        CFG_CHUNK_BLOCKS = 1'b0,
        CFG_PAGE_BLOCKS  = 1'b1
    } t_cfg_idx;

    // Operation codes.
    localparam logic OP_CHUNK = 1'b0;
    localparam logic OP_PAGE  = 1'b1;

endpackage

// ===== hdl/brs_req_if.sv =====
interface brs_req_if #(
    parameter int ADDRESS_BITS = brs_pkg::ADDRESS_BITS_DEF,
    parameter int LENGTH_BITS  = brs_pkg::LENGTH_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [ADDRESS_BITS-1:0] block_address;
    logic [LENGTH_BITS-1:0]  block_count;
    logic [ADDRESS_BITS-1:0] chunk_number;
    logic [LENGTH_BITS-1:0]  span_start;
    logic [LENGTH_BITS-1:0]  span_end;

    modport source (
        output valid, operation, block_address, block_count,
        output chunk_number, span_start, span_end,
        input  ready
    );
    modport sink (
        input  valid, operation, block_address, block_count,
        input  chunk_number, span_start, span_end,
        output ready
    );
endinterface

// ===== hdl/brs_rsp_if.sv =====
interface brs_rsp_if #(
    parameter int ADDRESS_BITS = brs_pkg::ADDRESS_BITS_DEF,
    parameter int LENGTH_BITS  = brs_pkg::LENGTH_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [ADDRESS_BITS-1:0] base_page;
    logic [ADDRESS_BITS-1:0] first_unit;
    logic [LENGTH_BITS-1:0]  first_offset;
    logic [ADDRESS_BITS-1:0] last_unit;
    logic [LENGTH_BITS-1:0]  last_offset;
    logic                    bad_span;

    modport source (
        output valid, base_page, first_unit, first_offset,
        output last_unit, last_offset, bad_span,
        input  ready
    );
    modport sink (
        input  valid, base_page, first_unit, first_offset,
        input  last_unit, last_offset, bad_span,
        output ready
    );
endinterface

// ===== hdl/brs_div_cell.sv =====
module brs_div_cell #(
    parameter int N = 49
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [brs_pkg::DIV_W-1:0] i_rem,
    input  logic [N-1:0]              i_dvd,
    input  logic [brs_pkg::DIV_W-1:0] i_div,
    output logic [brs_pkg::DIV_W-1:0] o_rem,
    output logic [N-1:0]              o_dvd,
    output logic [brs_pkg::DIV_W-1:0] o_div
);
    import brs_pkg::*;

    logic [DIV_W:0]   w_trial;
    logic             w_ge;
    logic [DIV_W:0]   w_diff;
    logic [DIV_W-1:0] n_rem;
    logic [N-1:0]     n_dvd;
    logic [DIV_W-1:0] r_rem;
    logic [N-1:0]     r_dvd;
    logic [DIV_W-1:0] r_div;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        w_trial = {i_rem, i_dvd[N-1]};
        w_diff  = w_trial - {1'b0, i_div};
        w_ge    = (w_trial >= {1'b0, i_div});
        n_rem   = w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
        n_dvd   = {i_dvd[N-2:0], w_ge};
    end

    // The step result moves on to the next cell.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
            r_div <= i_div;
        end
    end

    assign o_rem = r_rem;
    assign o_dvd = r_dvd;
    assign o_div = r_div;
endmodule

// ===== hdl/brs_mul.sv =====
module brs_mul #(
    parameter int ADDRESS_BITS = brs_pkg::ADDRESS_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [ADDRESS_BITS-1:0]   i_cidx,
    input  logic [brs_pkg::DIV_W-1:0] i_q,
    output logic [ADDRESS_BITS-1:0]   o_prod
);
    import brs_pkg::*;

    logic [63:0]        w_cidx;
    logic [63:0]        r_p0;
    logic [DIV_W-1:0]   r_p1;
    logic [63:0]        w_sum;
    logic [ADDRESS_BITS-1:0] r_prod;

    assign w_cidx = 64'(i_cidx);
    assign w_sum  = r_p0 + {r_p1, 32'd0};

    // Two 32 by 32 partial products, then one add, modulo the address width.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0   <= 64'(w_cidx[31:0]) * 64'(i_q);
            r_p1   <= 32'(w_cidx[63:32] * i_q);
            r_prod <= w_sum[ADDRESS_BITS-1:0];
        end
    end

    assign o_prod = r_prod;
endmodule

// ===== hdl/block_range_splitter_top.sv =====
// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    operation, block_address, block_count, chunk_number,
//                               span_start, span_end
// o_rsp     out  valid/ready    base_page, first_unit, first_offset, last_unit,
//                               last_offset, bad_span
// i_cfg_*   in   write enable   index, data
//
// One item per cycle is accepted while the skid buffer is empty. N, the number of
// divider cells, is max(max(ADDRESS_BITS, LENGTH_BITS) + 1, 32). The datapath is the
// row of restoring divider cells, one quotient bit each, followed by two stages of
// the base page multiplier.
// A one-item skid buffer at the output takes a result when o_rsp stalls; the row
// freezes only while that buffer is full. Reset clears valid bits and resets the config registers.
module block_range_splitter_top #(
    parameter int ADDRESS_BITS = brs_pkg::ADDRESS_BITS_DEF,
    parameter int LENGTH_BITS  = brs_pkg::LENGTH_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  brs_pkg::t_cfg_idx         i_cfg_index,
    input  logic [brs_pkg::CFG_W-1:0] i_cfg_data,
    brs_req_if.sink                   i_req,
    brs_rsp_if.source                 o_rsp
);
    import brs_pkg::*;

    localparam int WIDE = (ADDRESS_BITS > LENGTH_BITS ? ADDRESS_BITS : LENGTH_BITS) + 1;
    localparam int N    = (WIDE > DIV_W) ? WIDE : DIV_W;
    localparam int S    = N + 2;

    typedef struct packed {
        logic [ADDRESS_BITS-1:0] base_page;
        logic [ADDRESS_BITS-1:0] first_unit;
        logic [LENGTH_BITS-1:0]  first_offset;
        logic [ADDRESS_BITS-1:0] last_unit;
        logic [LENGTH_BITS-1:0]  last_offset;
        logic                    bad_span;
    } t_rsp;

    logic [DIV_W-1:0]  r_chunk;
    logic [PAGE_W-1:0] r_page;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= CHUNK_RESET;
            r_page  <= PAGE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHUNK_BLOCKS: r_chunk <= i_cfg_data[DIV_W-1:0];
                CFG_PAGE_BLOCKS:  r_page  <= i_cfg_data[PAGE_W-1:0];
                default:          r_chunk <= r_chunk;
            endcase
        end
    end

    logic             en;
    logic [S-1:0]     r_v;
    logic             r_skid_v;
    t_rsp             r_skid;

    assign en          = !r_skid_v;
    assign i_req.ready = en && i_rst_n;

    // Lane 0 finds the first unit, lane 1 the last unit, lane 2 pages per chunk.
    logic [DIV_W-1:0] w_rem [N+1][3];
    logic [N-1:0]     w_dvd [N+1][3];
    logic [DIV_W-1:0] w_div [N+1][3];

    logic [DIV_W-1:0] w_chunk1;
    logic [DIV_W-1:0] w_page1;
    logic [DIV_W-1:0] w_unit;
    logic             w_empty;
    logic             w_bad;

    // Entry: zero chunk and page sizes count as one, and both ends are set up for division.
    always_comb begin
        w_chunk1 = (r_chunk == '0) ? DIV_W'(1) : r_chunk;
        w_page1  = (r_page == '0) ? DIV_W'(1) : DIV_W'(r_page);
        w_unit   = (i_req.operation == OP_PAGE) ? w_page1 : w_chunk1;
        w_bad    = (i_req.operation == OP_PAGE) && (i_req.span_end < i_req.span_start);
        if (i_req.operation == OP_PAGE) begin
            w_empty     = (i_req.span_end <= i_req.span_start);
            w_dvd[0][0] = N'(i_req.span_start);
            w_dvd[0][1] = N'(i_req.span_end) - N'(1);
        end else begin
            w_empty     = (i_req.block_count == '0);
            w_dvd[0][0] = N'(i_req.block_address);
            w_dvd[0][1] = N'(i_req.block_address) + N'(i_req.block_count) - N'(1);
        end
        w_dvd[0][2] = N'(w_chunk1);
        w_div[0][0] = w_unit;
        w_div[0][1] = w_unit;
        w_div[0][2] = w_page1;
        w_rem[0][0] = '0;
        w_rem[0][1] = '0;
        w_rem[0][2] = '0;
    end

    logic                    r_empty [N];
    logic                    r_bad   [N];
    logic [ADDRESS_BITS-1:0] r_cidx  [N];

    // The row of divider cells, with the item's side data beside each one.
    for (genvar k = 0; k < N; k++) begin : g_row
        for (genvar l = 0; l < 3; l++) begin : g_lane
            brs_div_cell #(.N(N)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_rem (w_rem[k][l]),
                .i_dvd (w_dvd[k][l]),
                .i_div (w_div[k][l]),
                .o_rem (w_rem[k+1][l]),
                .o_dvd (w_dvd[k+1][l]),
                .o_div (w_div[k+1][l])
            );
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (k == 0) begin
                    r_empty[k] <= w_empty;
                    r_bad[k]   <= w_bad;
                    r_cidx[k]  <= (i_req.operation == OP_PAGE) ? i_req.chunk_number : '0;
                end else begin
                    r_empty[k] <= r_empty[k-1];
                    r_bad[k]   <= r_bad[k-1];
                    r_cidx[k]  <= r_cidx[k-1];
                end
            end
        end
    end

    // Valid bits move with the row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[S-2:0], i_req.valid};
        end
    end

    logic [ADDRESS_BITS-1:0] w_prod;

    brs_mul #(.ADDRESS_BITS(ADDRESS_BITS)) u_mul (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cidx (r_cidx[N-1]),
        .i_q    (w_dvd[N][2][DIV_W-1:0]),
        .o_prod (w_prod)
    );

    t_rsp r1;
    t_rsp r2;
    t_rsp w_res;
    t_rsp w_pipe;
    logic [DIV_W:0] w_end;

    // Results: an empty span ends where it starts, otherwise the end is rem + 1.
    always_comb begin
        w_end              = {1'b0, w_rem[N][1]} + (DIV_W+1)'(1);
        w_res.base_page    = '0;
        w_res.first_unit   = w_dvd[N][0][ADDRESS_BITS-1:0];
        w_res.first_offset = LENGTH_BITS'(w_rem[N][0]);
        w_res.bad_span     = r_bad[N-1];
        if (r_empty[N-1]) begin
            w_res.last_unit   = w_res.first_unit;
            w_res.last_offset = w_res.first_offset;
        end else begin
            w_res.last_unit   = w_dvd[N][1][ADDRESS_BITS-1:0];
            w_res.last_offset = LENGTH_BITS'(w_end);
        end
    end

    // Two stages in step with the multiplier.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1 <= w_res;
            r2 <= r1;
        end
    end

    // The last stage joined with the base page from the multiplier.
    always_comb begin
        w_pipe           = r2;
        w_pipe.base_page = w_prod;
    end

    // Skid buffer for a result that meets a stalled output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v && o_rsp.ready) begin
            r_skid_v <= 1'b0;
        end else if (en && r_v[S-1] && !o_rsp.ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v[S-1] && !o_rsp.ready) begin
            r_skid <= w_pipe;
        end
    end

    // Output selection: the skid entry goes first.
    always_comb begin
        o_rsp.valid = r_skid_v || r_v[S-1];
        if (r_skid_v) begin
            o_rsp.base_page    = r_skid.base_page;
            o_rsp.first_unit   = r_skid.first_unit;
            o_rsp.first_offset = r_skid.first_offset;
            o_rsp.last_unit    = r_skid.last_unit;
            o_rsp.last_offset  = r_skid.last_offset;
            o_rsp.bad_span     = r_skid.bad_span;
        end else begin
            o_rsp.base_page    = w_pipe.base_page;
            o_rsp.first_unit   = w_pipe.first_unit;
            o_rsp.first_offset = w_pipe.first_offset;
            o_rsp.last_unit    = w_pipe.last_unit;
            o_rsp.last_offset  = w_pipe.last_offset;
            o_rsp.bad_span     = w_pipe.bad_span;
        end
    end

    // A reversed span is reported as empty.
    a_bad_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.bad_span |->
            (o_rsp.last_unit == o_rsp.first_unit) &&
            (o_rsp.last_offset == o_rsp.first_offset))
        else $error("bad span item is not empty");

    // The skid buffer only fills when the output was stalled.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(!o_rsp.ready) && $past(r_v[S-1]))
        else $error("skid filled without a stalled result");

    // No result is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("result valid after reset");

endmodule
